FILE: rtl/core/lpfcc_pkg.sv
package lpfcc_pkg;

  localparam logic [15:0] CRC_POLY   = 16'h8408;
  localparam logic [15:0] CRC_PRESET = 16'hFFFF;
  localparam logic [7:0]  MIN_LENGTH = 8'd4;

  localparam logic [2:0] PH_LENGTH  = 3'd0;
  localparam logic [2:0] PH_ADDRESS = 3'd1;
  localparam logic [2:0] PH_STATUS  = 3'd2;
  localparam logic [2:0] PH_DATA    = 3'd3;
  localparam logic [2:0] PH_CRC_LO  = 3'd4;
  localparam logic [2:0] PH_CRC_HI  = 3'd5;

  localparam logic [2:0] KIND_LENGTH  = 3'd0;
  localparam logic [2:0] KIND_ADDRESS = 3'd1;
  localparam logic [2:0] KIND_STATUS  = 3'd2;
  localparam logic [2:0] KIND_DATA    = 3'd3;
  localparam logic [2:0] KIND_CRC_LO  = 3'd4;
  localparam logic [2:0] KIND_CRC_HI  = 3'd5;

  typedef struct packed {
    logic       length_error;
    logic       crc_ok;
    logic       frame_end;
    logic [7:0] data_index;
    logic [2:0] field_kind;
    logic [7:0] byte_value;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/core/length_prefixed_frame_crc_checker.sv
// Channel  Direction  Handshake                  Payload
// s_       in         s_tvalid / s_tready        s_tdata: received byte
// m_       out        m_tvalid / m_tready        m_tdata, m_tuser, m_tlast: labelled byte
//
// Each word passes an input register and a result register; one word a cycle
// is sustained while the output is not stalled. The CRC update of one byte is
// combinational XOR logic.
// Reset clears the valid flags and returns the parser to the length byte.
// A stalled output holds its result; the input register still takes one
// more word while the result register is full.
module length_prefixed_frame_crc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] byte_value, [15:8] data_index
  output logic [4:0]  m_tuser,   // [2:0] field_kind, [3] crc_ok, [4] length_error
  output logic        m_tlast    // frame_end
);

  logic               in_valid;
  logic [7:0]         in_byte;
  logic               out_load;
  lpfcc_pkg::result_t result;
  lpfcc_pkg::result_t out_result;

  assign out_load = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || out_load;

  lpfcc_frame_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .step    (out_load),
    .rx_byte (in_byte),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
    if (out_load) begin
      out_result <= result;
    end
  end

  assign m_tdata = {out_result.data_index, out_result.byte_value};
  assign m_tuser = {out_result.length_error, out_result.crc_ok, out_result.field_kind};
  assign m_tlast = out_result.frame_end;

endmodule

FILE: rtl/core/lpfcc_frame_fsm.sv
module lpfcc_frame_fsm (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  output lpfcc_pkg::result_t  result
);

  logic [2:0]  phase;
  logic [2:0]  phase_next;
  logic [7:0]  bytes_left;
  logic [7:0]  bytes_left_next;
  logic [15:0] running_crc;
  logic [15:0] running_crc_next;
  logic [7:0]  received_crc_low;
  logic [7:0]  received_crc_low_next;
  logic [7:0]  data_count;
  logic [7:0]  data_count_next;
  logic [15:0] crc_step;

  assign crc_step = lpfcc_pkg::crc_byte(running_crc, rx_byte);

  always_comb begin
    phase_next            = phase;
    bytes_left_next       = bytes_left;
    running_crc_next      = running_crc;
    received_crc_low_next = received_crc_low;
    data_count_next       = data_count;
    result.byte_value     = rx_byte;
    result.field_kind     = lpfcc_pkg::KIND_LENGTH;
    result.data_index     = 8'd0;
    result.frame_end      = 1'b0;
    result.crc_ok         = 1'b0;
    result.length_error   = 1'b0;
    case (phase)
      lpfcc_pkg::PH_ADDRESS: begin
        result.field_kind = lpfcc_pkg::KIND_ADDRESS;
        running_crc_next  = crc_step;
        phase_next        = lpfcc_pkg::PH_STATUS;
      end
      lpfcc_pkg::PH_STATUS: begin
        result.field_kind = lpfcc_pkg::KIND_STATUS;
        running_crc_next  = crc_step;
        data_count_next   = 8'd0;
        phase_next        = (bytes_left != 8'd0) ? lpfcc_pkg::PH_DATA : lpfcc_pkg::PH_CRC_LO;
      end
      lpfcc_pkg::PH_DATA: begin
        result.field_kind = lpfcc_pkg::KIND_DATA;
        result.data_index = data_count;
        running_crc_next  = crc_step;
        data_count_next   = data_count + 8'd1;
        bytes_left_next   = bytes_left - 8'd1;
        if (bytes_left == 8'd1) begin
          phase_next = lpfcc_pkg::PH_CRC_LO;
        end
      end
      lpfcc_pkg::PH_CRC_LO: begin
        result.field_kind     = lpfcc_pkg::KIND_CRC_LO;
        received_crc_low_next = rx_byte;
        phase_next            = lpfcc_pkg::PH_CRC_HI;
      end
      lpfcc_pkg::PH_CRC_HI: begin
        result.field_kind = lpfcc_pkg::KIND_CRC_HI;
        result.frame_end  = 1'b1;
        result.crc_ok     = ({rx_byte, received_crc_low} == running_crc);
        phase_next        = lpfcc_pkg::PH_LENGTH;
      end
      default: begin
        data_count_next = 8'd0;
        if (rx_byte < lpfcc_pkg::MIN_LENGTH) begin
          running_crc_next    = lpfcc_pkg::CRC_PRESET;
          result.frame_end    = 1'b1;
          result.length_error = 1'b1;
          bytes_left_next     = 8'd0;
          phase_next          = lpfcc_pkg::PH_LENGTH;
        end else begin
          running_crc_next = lpfcc_pkg::crc_byte(lpfcc_pkg::CRC_PRESET, rx_byte);
          bytes_left_next  = rx_byte - lpfcc_pkg::MIN_LENGTH;
          phase_next       = lpfcc_pkg::PH_ADDRESS;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= lpfcc_pkg::PH_LENGTH;
      bytes_left       <= 8'd0;
      running_crc      <= lpfcc_pkg::CRC_PRESET;
      received_crc_low <= 8'd0;
      data_count       <= 8'd0;
    end else if (step) begin
      phase            <= phase_next;
      bytes_left       <= bytes_left_next;
      running_crc      <= running_crc_next;
      received_crc_low <= received_crc_low_next;
      data_count       <= data_count_next;
    end
  end

endmodule
